### sv/tcc_pkg.sv
// tcc_pkg: shared constants, codes and types for the text console cursor
// no dependencies; imported by tcc_regs and text_console_cursor
package tcc_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IDX_W   = 11;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int TAB_W   = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // wide enough for any col + row * COLUMNS before masking
  localparam int IDXF_W  = COL_W + ROW_W + 1;

  // character codes with special handling
  localparam logic [CHAR_W-1:0] CODE_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] BLANK    = 8'd32;

  // result kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // register word indexes
  localparam logic REG_ATTR = 1'b0;
  localparam logic REG_TAB  = 1'b1;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [TAB_W-1:0]  TAB_RESET  = 4'h4;

  typedef struct packed {
    logic [ATTR_W-1:0] text_attribute;
    logic [TAB_W-1:0]  tab_width;
  } cfg_t;

  // tab spacing limited to 1..8
  function automatic logic [TAB_W-1:0] clamp_tab(input logic [TAB_W-1:0] tw);
    logic [TAB_W-1:0] r;
    r = tw;
    if (tw == '0) r = 4'd1;
    else if (tw > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

### sv/tcc_regs.sv
// tcc_regs: apb register file holding text attribute and tab width
// depends on tcc_pkg
module tcc_regs
  import tcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;
  logic word;

  assign pready = 1'b1;
  assign word   = paddr[2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_attribute <= ATTR_RESET;
      cfg.tab_width      <= TAB_RESET;
    end else if (wr_en) begin
      unique case (word)
        REG_ATTR: cfg.text_attribute <= pwdata[ATTR_W-1:0];
        REG_TAB:  cfg.tab_width      <= pwdata[TAB_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (word)
      REG_ATTR: prdata = {{(DATA_W-ATTR_W){1'b0}}, cfg.text_attribute};
      REG_TAB:  prdata = {{(DATA_W-TAB_W){1'b0}}, cfg.tab_width};
      default:  prdata = '0;
    endcase
  end

endmodule

### sv/text_console_cursor.sv
// text_console_cursor: cursor control for a text-mode console, one char per request
// printable or backspace: one cell write, none for backspace at column 0
// in_stall holds off new requests until every result of the last one has loaded
// the tab stop remainder comes from one shared subtractor, one quotient bit per cycle
// sync reset homes the cursor, attribute 7, tab width 4, output empty
// depends on tcc_pkg and tcc_regs
module text_console_cursor
  import tcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // character request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] char_code,
  // cell write / clear channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              action,
  output logic [IDX_W-1:0]  cell_index,
  output logic [CHAR_W-1:0] cell_char,
  output logic [ATTR_W-1:0] cell_attr,
  output logic              last_of_run,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,   // one cell at the cursor, then maybe advance
    ST_DIV,    // col % tab width, one bit per cycle
    ST_TAB,    // blanks up to the next tab stop
    ST_CLEAR   // clear-screen result, cursor home
  } state_t;

  cfg_t cfg;

  tcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t            state;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CHAR_W-1:0] ch;        // character of the pending write
  logic              adv;       // advance cursor after the write
  logic [TAB_W-1:0]  tw;        // clamped tab width for this request
  logic [TAB_W-1:0]  rem;       // running col % tw
  logic [COL_W-1:0]  dsh;       // dividend bits still to shift in
  logic [2:0]        div_cnt;

  // shared datapath
  logic              can_emit;
  logic              out_load;
  logic [COL_W:0]    ncol;
  logic              wrap;
  logic [ROW_W-1:0]  nrow;
  logic              clr;
  logic [ROW_W-1:0]  lf_row;
  logic              lf_clr;
  logic [TAB_W-1:0]  rem_inc;
  logic [TAB_W-1:0]  rem_next;
  logic              tab_done;
  logic [TAB_W-1:0]  rsh;
  logic [TAB_W-1:0]  rsub;
  logic [IDXF_W-1:0] idx_full;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    // output register free this cycle
    can_emit = !out_valid || !out_stall;
    // a new result is loaded this cycle
    out_load = can_emit && (state == ST_EMIT || state == ST_TAB || state == ST_CLEAR);
    // cursor step and line wrap
    ncol     = {1'b0, cursor_col} + {{COL_W{1'b0}}, adv};
    wrap     = ncol >= (COL_W+1)'(COLUMNS);
    nrow     = cursor_row + {{(ROW_W-1){1'b0}}, wrap};
    clr      = nrow >= ROW_W'(ROWS);
    lf_row   = cursor_row + {{(ROW_W-1){1'b0}}, 1'b1};
    lf_clr   = lf_row >= ROW_W'(ROWS);
    // tab stop tracking
    rem_inc  = rem + {{(TAB_W-1){1'b0}}, 1'b1};
    rem_next = (rem_inc == tw) ? '0 : rem_inc;
    tab_done = (rem_next == '0) || wrap;
    // restoring remainder step, rem stays below tw so its top bit is spare
    rsh      = {rem[TAB_W-2:0], dsh[COL_W-1]};
    rsub     = (rsh >= tw) ? rsh - tw : rsh;
    // cell address, masked to the index width
    idx_full = IDXF_W'(cursor_col) + IDXF_W'(cursor_row) * IDXF_W'(COLUMNS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      out_valid  <= 1'b0;
    end else begin
      // hold a stalled result, load a new one when the register is free
      out_valid <= out_load || (out_valid && out_stall);

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (char_code)
              CODE_TAB: begin
                tw      <= clamp_tab(cfg.tab_width);
                rem     <= '0;
                dsh     <= cursor_col;
                div_cnt <= '0;
                adv     <= 1'b1;
                state   <= ST_DIV;
              end
              CODE_BS: begin
                // step back and blank the landing cell, nothing at column 0
                if (cursor_col != '0) begin
                  cursor_col <= cursor_col - {{(COL_W-1){1'b0}}, 1'b1};
                  ch         <= BLANK;
                  adv        <= 1'b0;
                  state      <= ST_EMIT;
                end
              end
              CODE_LF: begin
                cursor_col <= '0;
                cursor_row <= lf_row;
                if (lf_clr) state <= ST_CLEAR;
              end
              CODE_CR: begin
                cursor_col <= '0;
              end
              default: begin
                ch    <= char_code;
                adv   <= 1'b1;
                state <= ST_EMIT;
              end
            endcase
          end
        end

        ST_EMIT: begin
          if (can_emit) begin
            action      <= ACT_WRITE;
            cell_index  <= idx_full[IDX_W-1:0];
            cell_char   <= ch;
            cell_attr   <= cfg.text_attribute;
            last_of_run <= !clr;
            cursor_col  <= wrap ? '0 : ncol[COL_W-1:0];
            cursor_row  <= nrow;
            state       <= clr ? ST_CLEAR : ST_IDLE;
          end
        end

        ST_DIV: begin
          rem     <= rsub;
          dsh     <= {dsh[COL_W-2:0], 1'b0};
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'(COL_W - 1)) state <= ST_TAB;
        end

        ST_TAB: begin
          if (can_emit) begin
            action      <= ACT_WRITE;
            cell_index  <= idx_full[IDX_W-1:0];
            cell_char   <= BLANK;
            cell_attr   <= cfg.text_attribute;
            last_of_run <= tab_done && !clr;
            rem         <= rem_next;
            if (tab_done) begin
              cursor_col <= wrap ? '0 : ncol[COL_W-1:0];
              cursor_row <= nrow;
              state      <= clr ? ST_CLEAR : ST_IDLE;
            end else begin
              cursor_col <= ncol[COL_W-1:0];
            end
          end
        end

        ST_CLEAR: begin
          if (can_emit) begin
            action      <= ACT_CLEAR;
            cell_index  <= '0;
            cell_char   <= '0;
            cell_attr   <= '0;
            last_of_run <= 1'b1;
            cursor_col  <= '0;
            cursor_row  <= '0;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // cursor never rests past the last column
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cursor_col < COL_W'(COLUMNS))
    else $error("cursor column out of range");

  // off the bottom only on the way to a clear
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cursor_row < ROW_W'(ROWS)))
    else $error("cursor row out of range while idle");

  // tab remainder stays below the tab width
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAB) |-> (rem < tw))
    else $error("tab remainder out of range");

  // a clear result carries no cell and closes the run
  a_clear_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_CLEAR) |-> (cell_index == '0 && last_of_run))
    else $error("clear result has cell payload");

  // a clear that is issued homes the cursor
  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && can_emit) |=> (cursor_col == '0 && cursor_row == '0))
    else $error("cursor not home after clear");
`endif

endmodule
